// ----- design/irwsf_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irwsf_pkg
// Shared types, constants and helpers for the IR wall sensor filter.
// ----------------------------------------------------------------------------
package irwsf_pkg;

    localparam int WINDOW_DEPTH  = 9;
    localparam int CHANNEL_COUNT = 4;
    localparam int SAMPLE_W      = 12;
    localparam int FIELD_W       = 16;
    localparam int CFG_IDX_W     = 4;

    localparam int SAMPLE_MAX = (1 << SAMPLE_W) - 1;
    localparam int SUM_W      = $clog2(WINDOW_DEPTH * SAMPLE_MAX + 1);
    localparam int EXT_W      = (SUM_W > FIELD_W) ? SUM_W : FIELD_W;
    localparam int SLOT_W     = $clog2(WINDOW_DEPTH);

    typedef logic [SAMPLE_W-1:0] t_sample;
    typedef logic [SUM_W-1:0]    t_sum;
    typedef logic [FIELD_W-1:0]  t_field;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [EXT_W-1:0]    t_ext;
    typedef logic [CHANNEL_COUNT-1:0][SUM_W-1:0] t_sum_vec;

    localparam t_ext FIELD_MAX = EXT_W'((1 << FIELD_W) - 1);

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_RIGHT_LOST_BELOW     = 4'd0,
        CFG_LEFT_LOST_BELOW      = 4'd1,
        CFG_FRONT_LEFT_AT_LEAST  = 4'd2,
        CFG_FRONT_RIGHT_AT_LEAST = 4'd3
    } t_cfg_index;

    localparam t_field RST_RIGHT_LOST_BELOW     = 16'd690;
    localparam t_field RST_LEFT_LOST_BELOW      = 16'd766;
    localparam t_field RST_FRONT_LEFT_AT_LEAST  = 16'd1367;
    localparam t_field RST_FRONT_RIGHT_AT_LEAST = 16'd1946;

    typedef struct packed {
        t_sample sample_right_front;
        t_sample sample_right;
        t_sample sample_left;
        t_sample sample_left_front;
        logic    check_side;
        logic    check_front;
    } t_in_item;

    typedef struct packed {
        t_field sum_right_front;
        t_field sum_right;
        t_field sum_left;
        t_field sum_left_front;
        logic   right_wall;
        logic   left_wall;
        logic   front_wall;
    } t_out_item;

    typedef struct packed {
        logic  accept;
        t_slot wr_slot;
        t_slot rd_slot;
        logic  filled;
    } t_lane_ctl;

    function automatic t_field sat_field(input t_sum s);
        t_ext ext;
        ext = EXT_W'(s);
        if (ext > FIELD_MAX) begin
            return '1;
        end
        return ext[FIELD_W-1:0];
    endfunction

    function automatic logic sum_below(input t_sum s, input t_field th);
        return EXT_W'(s) < EXT_W'(th);
    endfunction

endpackage
`default_nettype wire

// ----- design/ir_wall_sensor_filter.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// ir_wall_sensor_filter
// Nine-frame moving sum over four IR channels with side and front wall flags.
// Results are registered in a two-entry output stage (output register; skid
// entry while output stalls) keeping input and output decoupled. Throughput:
// one item per cycle while the skid entry is empty, set by the lane sum update.
// Reset: synchronous, active low; sums clear, side flags set, front flag
// clears, thresholds load defaults; the window reads as zeros until refilled.
// ----------------------------------------------------------------------------
module ir_wall_sensor_filter
    import irwsf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_in_valid,
    output logic                      o_in_ready,
    input  wire t_in_item             i_in_item,
    output logic                      o_out_valid,
    input  wire logic                 i_out_ready,
    output t_out_item                 o_out_item,
    input  wire logic                 i_cfg_valid,
    output logic                      o_cfg_ready,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire t_field               i_cfg_data
);

    logic      in_accept;
    t_slot     r_slot;
    t_slot     next_slot;
    logic      r_filled;
    t_lane_ctl lane_ctl;
    t_sample   samples [CHANNEL_COUNT];
    t_sum_vec  next_sums;
    t_out_item result;

    logic      r_out_valid;
    t_out_item r_out_item;
    logic      r_skid_valid;
    t_out_item r_skid_item;
    logic      n_out_valid;
    t_out_item n_out_item;
    logic      n_skid_valid;
    t_out_item n_skid_item;

    assign o_in_ready  = ~r_skid_valid;
    assign in_accept   = i_in_valid & o_in_ready;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out_item;

    always_comb begin
        next_slot = (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) ? '0 : r_slot + 1'b1;
        lane_ctl.accept  = in_accept;
        lane_ctl.wr_slot = r_slot;
        lane_ctl.rd_slot = in_accept ? next_slot : r_slot;
        lane_ctl.filled  = r_filled;
        samples[0] = i_in_item.sample_right_front;
        samples[1] = i_in_item.sample_right;
        samples[2] = i_in_item.sample_left;
        samples[3] = i_in_item.sample_left_front;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_slot   <= '0;
            r_filled <= 1'b0;
        end else if (in_accept) begin
            r_slot <= next_slot;
            if (r_slot == SLOT_W'(WINDOW_DEPTH - 1)) begin
                r_filled <= 1'b1;
            end
        end
    end

    for (genvar g = 0; g < CHANNEL_COUNT; g++) begin : g_lane
        irwsf_lane u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (lane_ctl),
            .i_sample   (samples[g]),
            .o_next_sum (next_sums[g])
        );
    end

    irwsf_merge u_merge (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_accept      (in_accept),
        .i_check_side  (i_in_item.check_side),
        .i_check_front (i_in_item.check_front),
        .i_sums        (next_sums),
        .i_cfg_write   (i_cfg_valid),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .o_item        (result)
    );

    always_comb begin
        n_out_valid  = r_out_valid;
        n_out_item   = r_out_item;
        n_skid_valid = r_skid_valid;
        n_skid_item  = r_skid_item;
        if (r_skid_valid) begin
            if (i_out_ready) begin
                n_out_item   = r_skid_item;
                n_skid_valid = 1'b0;
            end
        end else if (in_accept) begin
            if (!r_out_valid || i_out_ready) begin
                n_out_valid = 1'b1;
                n_out_item  = result;
            end else begin
                n_skid_valid = 1'b1;
                n_skid_item  = result;
            end
        end else if (i_out_ready) begin
            n_out_valid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid  <= 1'b0;
            r_skid_valid <= 1'b0;
        end else begin
            r_out_valid  <= n_out_valid;
            r_skid_valid <= n_skid_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_out_item  <= n_out_item;
        r_skid_item <= n_skid_item;
    end

    a_skid_needs_out: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_skid_valid |-> r_out_valid)
        else $error("skid entry held while output register empty");

    a_slot_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_slot <= SLOT_W'(WINDOW_DEPTH - 1))
        else $error("window slot out of range");

    a_stall_fills_skid: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (in_accept && r_out_valid && !i_out_ready) |=> r_skid_valid)
        else $error("item accepted under stall did not land in skid entry");

    a_filled_stays: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_filled |=> r_filled)
        else $error("window fill flag dropped");

endmodule
`default_nettype wire

// ----- design/irwsf_lane.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irwsf_lane
// One channel: window memory and running sum updated once per item.
// ----------------------------------------------------------------------------
module irwsf_lane
    import irwsf_pkg::*;
(
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire t_lane_ctl i_ctl,
    input  wire t_sample   i_sample,
    output t_sum           o_next_sum
);

    t_sample r_mem [WINDOW_DEPTH];
    t_sample r_oldest_raw;
    t_sample oldest;
    t_sum    r_sum;
    t_sum    n_sum;

    always_comb begin
        oldest = i_ctl.filled ? r_oldest_raw : '0;
        n_sum  = r_sum - SUM_W'(oldest) + SUM_W'(i_sample);
    end

    assign o_next_sum = n_sum;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
        end else if (i_ctl.accept) begin
            r_sum <= n_sum;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.accept) begin
            r_mem[i_ctl.wr_slot] <= i_sample;
        end
        r_oldest_raw <= r_mem[i_ctl.rd_slot];
    end

endmodule
`default_nettype wire

// ----- design/irwsf_merge.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// irwsf_merge
// Configuration registers, wall flags and assembly of the result item.
// ----------------------------------------------------------------------------
module irwsf_merge
    import irwsf_pkg::*;
(
    input  wire logic                 i_clk,
    input  wire logic                 i_rst_n,
    input  wire logic                 i_accept,
    input  wire logic                 i_check_side,
    input  wire logic                 i_check_front,
    input  wire t_sum_vec             i_sums,
    input  wire logic                 i_cfg_write,
    input  wire logic [CFG_IDX_W-1:0] i_cfg_index,
    input  wire t_field               i_cfg_data,
    output t_out_item                 o_item
);

    t_field r_right_lost;
    t_field r_left_lost;
    t_field r_front_left;
    t_field r_front_right;
    logic   r_right_flag;
    logic   r_left_flag;
    logic   r_front_flag;
    logic   n_right_flag;
    logic   n_left_flag;
    logic   n_front_flag;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_lost  <= RST_RIGHT_LOST_BELOW;
            r_left_lost   <= RST_LEFT_LOST_BELOW;
            r_front_left  <= RST_FRONT_LEFT_AT_LEAST;
            r_front_right <= RST_FRONT_RIGHT_AT_LEAST;
        end else if (i_cfg_write) begin
            case (i_cfg_index)
                CFG_RIGHT_LOST_BELOW:     r_right_lost  <= i_cfg_data;
                CFG_LEFT_LOST_BELOW:      r_left_lost   <= i_cfg_data;
                CFG_FRONT_LEFT_AT_LEAST:  r_front_left  <= i_cfg_data;
                CFG_FRONT_RIGHT_AT_LEAST: r_front_right <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_comb begin
        n_right_flag = r_right_flag & ~(i_check_side & sum_below(i_sums[0], r_right_lost));
        n_left_flag  = r_left_flag & ~(i_check_side & sum_below(i_sums[3], r_left_lost));
        n_front_flag = r_front_flag;
        if (i_check_front) begin
            n_front_flag = ~sum_below(i_sums[2], r_front_left) &
                           ~sum_below(i_sums[1], r_front_right);
        end
        o_item.sum_right_front = sat_field(i_sums[0]);
        o_item.sum_right       = sat_field(i_sums[1]);
        o_item.sum_left        = sat_field(i_sums[2]);
        o_item.sum_left_front  = sat_field(i_sums[3]);
        o_item.right_wall      = n_right_flag;
        o_item.left_wall       = n_left_flag;
        o_item.front_wall      = n_front_flag;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_right_flag <= 1'b1;
            r_left_flag  <= 1'b1;
            r_front_flag <= 1'b0;
        end else if (i_accept) begin
            r_right_flag <= n_right_flag;
            r_left_flag  <= n_left_flag;
            r_front_flag <= n_front_flag;
        end
    end

    a_right_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_right_flag |=> !r_right_flag)
        else $error("right wall flag left its latched state");

    a_left_latched: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_left_flag |=> !r_left_flag)
        else $error("left wall flag left its latched state");

endmodule
`default_nettype wire

// ----- tb/sv/ir_wall_sensor_filter_tb.sv -----
// ----------------------------------------------------------------------------
// ir_wall_sensor_filter_tb
// Drives sample frames and threshold writes into the IR wall sensor filter and
// checks every result item against an in-bench model of the nine-frame window,
// the running sums, latched side flags and front flag, or a pinned probe item.
// ----------------------------------------------------------------------------
module ir_wall_sensor_filter_tb;
    timeunit 1ns;
    timeprecision 1ps;
    import irwsf_pkg::*;

    localparam int RESET_CYCLES   = 12;
    localparam int PHASES         = 6;
    localparam int PHASE_FRAMES   = 310;
    localparam int IDLE_LIMIT     = 5000;
    localparam int SQUEEZE_AT     = 600;
    localparam int SQUEEZE_CYCLES = 300;
    localparam int TAIL_CYCLES    = 8;
    localparam int REPORT_LIMIT   = 10;
    localparam int PROBE_ROWS     = 23;
    localparam int UNUSED_INDEX_LO = int'(CFG_FRONT_RIGHT_AT_LEAST) + 1;
    localparam int UNUSED_INDEX_HI = (1 << CFG_IDX_W) - 1;

    localparam t_sample   TOP      = t_sample'(SAMPLE_MAX);
    localparam t_field    SUM_FULL = 16'd36855;
    localparam t_out_item NO_WANT  = '0;

    typedef enum int {LV_ANY, LV_LOW, LV_HIGH, LV_RAIL} t_level;
    typedef enum int {RS_OPEN, RS_COIN, RS_CADENCE, RS_STARVED} t_ready_style;

    typedef struct packed {
        t_in_item  frame;
        logic      pinned;
        t_out_item want;
    } t_probe;

    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_in_valid  = 1'b0;
    logic                 o_in_ready;
    t_in_item             i_in_item   = '0;
    logic                 o_out_valid;
    logic                 i_out_ready = 1'b0;
    t_out_item            o_out_item;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    t_field               i_cfg_data  = '0;

    logic      pin_has  = 1'b0;
    t_out_item pin_want = '0;

    t_sample     window_img [WINDOW_DEPTH][CHANNEL_COUNT];
    int unsigned write_pos;
    int unsigned run_sum [CHANNEL_COUNT];
    logic        right_latch;
    logic        left_latch;
    logic        front_seen;
    t_field      th_right_lost;
    t_field      th_left_lost;
    t_field      th_front_left;
    t_field      th_front_right;

    t_out_item   result_q [$];
    int unsigned fault_count  = 0;
    int unsigned results_seen = 0;
    int unsigned frames_taken = 0;
    int unsigned idle_cycles  = 0;

    t_probe probe_table [PROBE_ROWS] = '{
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0}},
        '{'{12'd690, 12'd1946, 12'd1367, 12'd766, 1'b1, 1'b1}, 1'b1,
          '{16'd690, 16'd1946, 16'd1367, 16'd766, 1'b1, 1'b1, 1'b1}},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{TOP, TOP, TOP, TOP, 1'b1, 1'b1}, 1'b1,
          '{SUM_FULL, SUM_FULL, SUM_FULL, SUM_FULL, 1'b1, 1'b1, 1'b1}},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b1, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b0}, 1'b0, NO_WANT},
        '{'{12'd0, 12'd0, 12'd0, 12'd0, 1'b0, 1'b1}, 1'b1,
          '{16'd0, 16'd0, 16'd0, 16'd0, 1'b1, 1'b1, 1'b0}},
        '{'{TOP, 12'd0, TOP, 12'd0, 1'b0, 1'b1}, 1'b1,
          '{16'd4095, 16'd0, 16'd4095, 16'd0, 1'b1, 1'b1, 1'b0}},
        '{'{12'd0, TOP, 12'd0, 12'd0, 1'b0, 1'b1}, 1'b1,
          '{16'd4095, 16'd4095, 16'd4095, 16'd0, 1'b1, 1'b1, 1'b1}},
        '{'{12'hAAA, 12'h555, 12'h555, 12'hAAA, 1'b1, 1'b1}, 1'b0, NO_WANT}
    };

    ir_wall_sensor_filter u_dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_in_item   (i_in_item),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_item  (o_out_item),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic t_field fit_field(input int unsigned v);
        return (v > ((1 << FIELD_W) - 1)) ? '1 : t_field'(v);
    endfunction

    function automatic string show_result(input t_out_item r);
        return $sformatf("sums %0d %0d %0d %0d walls R%0b L%0b F%0b",
                         r.sum_right_front, r.sum_right, r.sum_left,
                         r.sum_left_front, r.right_wall, r.left_wall, r.front_wall);
    endfunction

    function automatic t_sample draw_sample(input t_level lv);
        case (lv)
            LV_LOW:  return t_sample'($urandom_range(0, 255));
            LV_HIGH: return t_sample'($urandom_range(SAMPLE_MAX - 255, SAMPLE_MAX));
            LV_RAIL: return ($urandom_range(0, 1) != 0) ? TOP : '0;
            default: return t_sample'($urandom_range(0, SAMPLE_MAX));
        endcase
    endfunction

    task automatic advance_window(input t_in_item frame, output t_out_item res);
        t_sample fresh [CHANNEL_COUNT];
        fresh[0] = frame.sample_right_front;
        fresh[1] = frame.sample_right;
        fresh[2] = frame.sample_left;
        fresh[3] = frame.sample_left_front;
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            run_sum[ch] = run_sum[ch] - window_img[write_pos][ch] + fresh[ch];
            window_img[write_pos][ch] = fresh[ch];
        end
        write_pos = (write_pos + 1 >= WINDOW_DEPTH) ? 0 : write_pos + 1;
        if (frame.check_side) begin
            if (right_latch && run_sum[0] < th_right_lost) right_latch = 1'b0;
            if (left_latch && run_sum[3] < th_left_lost) left_latch = 1'b0;
        end
        if (frame.check_front) begin
            front_seen = (run_sum[2] >= th_front_left) && (run_sum[1] >= th_front_right);
        end
        res.sum_right_front = fit_field(run_sum[0]);
        res.sum_right       = fit_field(run_sum[1]);
        res.sum_left        = fit_field(run_sum[2]);
        res.sum_left_front  = fit_field(run_sum[3]);
        res.right_wall      = right_latch;
        res.left_wall       = left_latch;
        res.front_wall      = front_seen;
    endtask

    task automatic note_fault(input string msg);
        fault_count++;
        if (fault_count <= REPORT_LIMIT) begin
            $display("ERROR at %0t: %s", $time, msg);
        end
    endtask

    task automatic offer_frame(input t_in_item frame, input logic pinned,
                               input t_out_item want);
        i_in_valid <= 1'b1;
        i_in_item  <= frame;
        pin_has    <= pinned;
        pin_want   <= want;
        do @(posedge i_clk); while (!o_in_ready);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input t_field data);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic wait_drained();
        i_in_valid <= 1'b0;
        @(posedge i_clk);
        while (result_q.size() != 0) @(posedge i_clk);
    endtask

    always @(posedge i_clk) begin : monitor
        t_out_item predicted;
        t_out_item oldest;
        logic      moved;
        moved = 1'b0;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) begin
                moved = 1'b1;
                case (i_cfg_index)
                    CFG_RIGHT_LOST_BELOW:     th_right_lost  = i_cfg_data;
                    CFG_LEFT_LOST_BELOW:      th_left_lost   = i_cfg_data;
                    CFG_FRONT_LEFT_AT_LEAST:  th_front_left  = i_cfg_data;
                    CFG_FRONT_RIGHT_AT_LEAST: th_front_right = i_cfg_data;
                    default: ;
                endcase
            end
            if (i_in_valid && o_in_ready) begin
                moved = 1'b1;
                advance_window(i_in_item, predicted);
                result_q.push_back(pin_has ? pin_want : predicted);
                frames_taken++;
            end
            if (o_out_valid && i_out_ready) begin
                moved = 1'b1;
                results_seen++;
                if (result_q.size() == 0) begin
                    note_fault($sformatf("unexpected result: %s", show_result(o_out_item)));
                end else begin
                    oldest = result_q.pop_front();
                    if (o_out_item !== oldest) begin
                        note_fault($sformatf("result %0d: expected %s, got %s", results_seen,
                                             show_result(oldest), show_result(o_out_item)));
                    end
                end
            end
            idle_cycles = moved ? 0 : idle_cycles + 1;
        end
    end

    initial begin : watchdog
        while (idle_cycles < IDLE_LIMIT) @(posedge i_clk);
        $display("Test completed with failures");
        $finish;
    end

    initial begin : out_side
        t_ready_style style;
        int unsigned  seg;
        bit           squeezed;
        squeezed = 1'b0;
        while (!i_rst_n) @(posedge i_clk);
        forever begin
            if (!squeezed && frames_taken >= SQUEEZE_AT) begin
                squeezed = 1'b1;
                i_out_ready <= 1'b0;
                repeat (SQUEEZE_CYCLES) @(posedge i_clk);
            end
            seg   = $urandom_range(8, 64);
            style = t_ready_style'($urandom_range(RS_OPEN, RS_STARVED));
            for (int k = 0; k < seg; k++) begin
                case (style)
                    RS_OPEN:    i_out_ready <= 1'b1;
                    RS_COIN:    i_out_ready <= 1'($urandom_range(0, 1));
                    RS_CADENCE: i_out_ready <= (k % 4 != 3);
                    default:    i_out_ready <= ($urandom_range(0, 3) == 0);
                endcase
                @(posedge i_clk);
            end
        end
    end

    initial begin : stimulus
        t_in_item    frame;
        t_level      lv;
        t_field      side_r;
        t_field      side_l;
        t_field      front_l;
        t_field      front_r;
        int unsigned sent;
        int unsigned burst;
        int unsigned gap;

        for (int s = 0; s < WINDOW_DEPTH; s++) begin
            for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
                window_img[s][ch] = '0;
            end
        end
        for (int ch = 0; ch < CHANNEL_COUNT; ch++) begin
            run_sum[ch] = 0;
        end
        write_pos      = 0;
        right_latch    = 1'b1;
        left_latch     = 1'b1;
        front_seen     = 1'b0;
        th_right_lost  = RST_RIGHT_LOST_BELOW;
        th_left_lost   = RST_LEFT_LOST_BELOW;
        th_front_left  = RST_FRONT_LEFT_AT_LEAST;
        th_front_right = RST_FRONT_RIGHT_AT_LEAST;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        for (int r = 0; r < PROBE_ROWS; r++) begin
            offer_frame(probe_table[r].frame, probe_table[r].pinned, probe_table[r].want);
        end

        for (int phase = 0; phase < PHASES; phase++) begin
            wait_drained();
            case (phase)
                0: begin
                    front_l = '0;
                    front_r = '0;
                end
                1: begin
                    front_l = SUM_FULL;
                    front_r = SUM_FULL;
                end
                2: begin
                    front_l = '1;
                    front_r = t_field'($urandom_range(0, SUM_FULL));
                end
                default: begin
                    front_l = t_field'($urandom_range(0, SUM_FULL));
                    front_r = t_field'($urandom_range(0, SUM_FULL));
                end
            endcase
            if (phase == PHASES - 1) begin
                side_r = t_field'($urandom_range(2000, 12000));
                side_l = t_field'($urandom_range(2000, 12000));
            end else begin
                side_r = '0;
                side_l = '0;
            end
            write_reg(CFG_RIGHT_LOST_BELOW, side_r);
            write_reg(CFG_LEFT_LOST_BELOW, side_l);
            write_reg(CFG_FRONT_LEFT_AT_LEAST, front_l);
            write_reg(CFG_FRONT_RIGHT_AT_LEAST, front_r);
            write_reg(CFG_IDX_W'($urandom_range(UNUSED_INDEX_LO, UNUSED_INDEX_HI)),
                      t_field'($urandom_range(0, (1 << FIELD_W) - 1)));
            i_cfg_valid <= 1'b0;

            sent = 0;
            while (sent < PHASE_FRAMES) begin
                burst = $urandom_range(1, 40);
                lv    = t_level'($urandom_range(LV_ANY, LV_RAIL));
                for (int k = 0; k < burst && sent < PHASE_FRAMES; k++) begin
                    frame.sample_right_front = draw_sample(lv);
                    frame.sample_right       = draw_sample(lv);
                    frame.sample_left        = draw_sample(lv);
                    frame.sample_left_front  = draw_sample(lv);
                    frame.check_side         = 1'($urandom_range(0, 1));
                    frame.check_front        = 1'($urandom_range(0, 1));
                    offer_frame(frame, 1'b0, NO_WANT);
                    sent++;
                end
                gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
                if (gap != 0) begin
                    i_in_valid <= 1'b0;
                    repeat (gap) @(posedge i_clk);
                end
            end
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge i_clk);
        if (fault_count == 0 && result_q.size() == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
